// File: rtl/smfp_pkg.sv
// Shared types and constants for the stack-map frame parser.
package smfp_pkg;

  // Input transfer: one attribute byte and its last-byte mark.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // Output transfer: one parsed record.
  typedef struct packed {
    logic [2:0]  record_kind;
    logic [2:0]  frame_kind;
    logic [7:0]  frame_tag;
    logic [31:0] bytecode_offset;
    logic [1:0]  locals_removed;
    logic [15:0] entry_count;
    logic [7:0]  type_tag;
    logic [15:0] type_value;
    logic        table_end;
    logic [1:0]  status;
  } out_item_t;

  // Classification of a byte when it is read as a frame tag.
  typedef enum logic [2:0] {
    TC_SAME_SHORT,
    TC_SL1_SHORT,
    TC_RESERVED,
    TC_SL1_EXT,
    TC_CHOP,
    TC_SAME_EXT,
    TC_APPEND,
    TC_FULL
  } tag_class_e;

  // Queue entry between the front and the back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    tag_class_e tag_class;
  } cls_item_t;

  // Parser phases.
  typedef enum logic [3:0] {
    PH_COUNT_HI,
    PH_COUNT_LO,
    PH_TAG,
    PH_DELTA_HI,
    PH_DELTA_LO,
    PH_LCOUNT_HI,
    PH_LCOUNT_LO,
    PH_TYPE_TAG,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_SCOUNT_HI,
    PH_SCOUNT_LO,
    PH_DONE
  } phase_e;

  // Frame kinds as reported.
  localparam logic [2:0] FK_SAME   = 3'd0;
  localparam logic [2:0] FK_SL1    = 3'd1;
  localparam logic [2:0] FK_CHOP   = 3'd2;
  localparam logic [2:0] FK_APPEND = 3'd3;
  localparam logic [2:0] FK_FULL   = 3'd4;

  // Record kinds.
  localparam logic [2:0] RK_HEADER  = 3'd0;
  localparam logic [2:0] RK_FRAME   = 3'd1;
  localparam logic [2:0] RK_LCOUNT  = 3'd2;
  localparam logic [2:0] RK_SCOUNT  = 3'd3;
  localparam logic [2:0] RK_LTYPE   = 3'd4;
  localparam logic [2:0] RK_STYPE   = 3'd5;
  localparam logic [2:0] RK_NONE    = 3'd6;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TRUNC    = 2'd1;
  localparam logic [1:0] ST_TRAILING = 2'd2;

  // Tag boundaries and verification tags with a payload.
  localparam logic [7:0] TAG_SAME_MAX  = 8'd63;
  localparam logic [7:0] TAG_SL1_MAX   = 8'd127;
  localparam logic [7:0] TAG_SL1_EXT   = 8'd247;
  localparam logic [7:0] TAG_SAME_EXT  = 8'd251;
  localparam logic [7:0] TAG_FULL      = 8'd255;
  localparam logic [7:0] VT_OBJECT     = 8'd7;
  localparam logic [7:0] VT_UNINIT     = 8'd8;

endpackage

// File: rtl/stack_map_frame_parser_top.sv
// Top level of the stack-map frame parser: front classifier, queue and parser back end.
// Each byte is registered in the front queue, and its record is registered in the result queue.
// Throughput: one byte per cycle while the result queue has room, set by the single parse step of the back end.
// The two-entry queues on each side let the input and output stall independently.
// Reset is asynchronous and active low; it empties both queues and sets the parser
// to expect the high byte of the frame count, with no clearing pass.
module stack_map_frame_parser_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  smfp_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output smfp_pkg::out_item_t out_data_o
);
  import smfp_pkg::*;

  logic      q_valid;
  logic      q_pop;
  cls_item_t q_item;

  // Byte intake and classification.
  smfp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_item_i (in_data_i),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_item_o  (q_item)
  );

  // Parsing and record output.
  smfp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_item_i   (q_item),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_data_o)
  );

endmodule

// File: rtl/smfp_front.sv
// Front end: accepts attribute bytes, classifies them as frame tags and queues them.
module smfp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  smfp_pkg::in_item_t  in_item_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output smfp_pkg::cls_item_t q_item_o
);
  import smfp_pkg::*;

  cls_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  tag_class_e cls;
  logic       do_wr, do_rd;

  // Tag classification of the incoming byte.
  always_comb begin
    logic [7:0] b;
    b = in_item_i.data_byte;
    if (b <= TAG_SAME_MAX) begin
      cls = TC_SAME_SHORT;
    end else if (b <= TAG_SL1_MAX) begin
      cls = TC_SL1_SHORT;
    end else if (b < TAG_SL1_EXT) begin
      cls = TC_RESERVED;
    end else if (b == TAG_SL1_EXT) begin
      cls = TC_SL1_EXT;
    end else if (b < TAG_SAME_EXT) begin
      cls = TC_CHOP;
    end else if (b == TAG_SAME_EXT) begin
      cls = TC_SAME_EXT;
    end else if (b < TAG_FULL) begin
      cls = TC_APPEND;
    end else begin
      cls = TC_FULL;
    end
  end

  // Queue pointers and occupancy.
  assign full_o    = (cnt_q == 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign do_wr     = push_i && !full_o;
  assign do_rd     = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= '{data_byte: in_item_i.data_byte,
                           last_byte: in_item_i.last_byte,
                           tag_class: cls};
    end
  end

endmodule

// File: rtl/smfp_back.sv
// Back end: parser state machine that turns classified bytes into queued records.
module smfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  smfp_pkg::cls_item_t q_item_i,
  output logic                empty_o,
  input  logic                pop_i,
  output smfp_pkg::out_item_t out_item_o
);
  import smfp_pkg::*;

  // Parser state.
  phase_e      phase_q, phase_d;
  logic [15:0] frames_left_q, frames_left_d;
  logic        first_q, first_d;
  logic [31:0] prev_q, prev_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  tag_q, tag_d;
  logic [15:0] types_left_q, types_left_d;
  logic        in_stack_q, in_stack_d;
  logic [7:0]  held_hi_q, held_hi_d;
  logic [7:0]  held_tt_q, held_tt_d;
  logic        drain_q, drain_d;

  // Result queue.
  out_item_t   res_q [2];
  logic        res_wr_q, res_rd_q;
  logic [1:0]  res_cnt_q, res_cnt_d;

  logic        fire;
  logic        have_rec;
  out_item_t   rec;
  logic        res_rd;

  assign fire    = q_valid_i && (res_cnt_q != 2'd2);
  assign q_pop_o = fire;

  // One parse step on the byte at the head of the front queue.
  always_comb begin
    phase_e      ph;
    logic [15:0] fl, tl, word, delta;
    logic        fst, ins, drn;
    logic [31:0] prv;
    logic [2:0]  knd;
    logic [7:0]  tg, hh, htt, b, chop_diff;
    logic        do_start, do_type, do_fd, ctx, end_f, last;
    logic [2:0]  rkind;
    logic [15:0] rcount, rtval;
    logic [7:0]  rttag;
    logic [1:0]  st;

    ph  = phase_q;  fl  = frames_left_q; fst = first_q;   prv = prev_q;
    knd = kind_q;   tg  = tag_q;         tl  = types_left_q;
    ins = in_stack_q; hh = held_hi_q;    htt = held_tt_q;  drn = drain_q;
    b    = q_item_i.data_byte;
    last = q_item_i.last_byte;
    word = {held_hi_q, b};
    delta = word;
    do_start = 1'b0; do_type = 1'b0; do_fd = 1'b0; ctx = 1'b0;
    have_rec = 1'b0; end_f = 1'b0; st = ST_OK;
    rkind = RK_NONE; rcount = 16'd0; rttag = 8'd0; rtval = 16'd0;
    chop_diff = 8'd0;
    rec = '0;

    if (!drain_q) begin
      // Phase dispatch.
      unique case (phase_q)
        PH_COUNT_HI: begin
          hh = b;
          ph = PH_COUNT_LO;
        end
        PH_COUNT_LO: begin
          fl = word;
          have_rec = 1'b1;
          rkind = RK_HEADER;
          rcount = word;
          ph = (word == 16'd0) ? PH_DONE : PH_TAG;
        end
        PH_TAG: begin
          tg = b;
          unique case (q_item_i.tag_class)
            TC_SAME_SHORT: begin
              knd = FK_SAME;
              delta = {10'd0, b[5:0]};
              do_start = 1'b1;
            end
            TC_SL1_SHORT: begin
              knd = FK_SL1;
              delta = {10'd0, b[5:0]};
              do_start = 1'b1;
            end
            TC_RESERVED: begin
              have_rec = 1'b1;
              rkind = RK_NONE;
              end_f = 1'b1;
              st = ST_TRUNC;
            end
            TC_SL1_EXT: begin
              knd = FK_SL1;
              ph = PH_DELTA_HI;
            end
            TC_CHOP: begin
              knd = FK_CHOP;
              ph = PH_DELTA_HI;
            end
            TC_SAME_EXT: begin
              knd = FK_SAME;
              ph = PH_DELTA_HI;
            end
            TC_APPEND: begin
              knd = FK_APPEND;
              ph = PH_DELTA_HI;
            end
            TC_FULL: begin
              knd = FK_FULL;
              ph = PH_DELTA_HI;
            end
            default: ;
          endcase
        end
        PH_DELTA_HI: begin
          hh = b;
          ph = PH_DELTA_LO;
        end
        PH_LCOUNT_HI: begin
          hh = b;
          ph = PH_LCOUNT_LO;
        end
        PH_TYPE_HI: begin
          hh = b;
          ph = PH_TYPE_LO;
        end
        PH_SCOUNT_HI: begin
          hh = b;
          ph = PH_SCOUNT_LO;
        end
        PH_DELTA_LO: begin
          do_start = 1'b1;
        end
        PH_LCOUNT_LO: begin
          have_rec = 1'b1;
          ctx = 1'b1;
          rkind = RK_LCOUNT;
          rcount = word;
          tl = word;
          ins = 1'b0;
          ph = (word == 16'd0) ? PH_SCOUNT_HI : PH_TYPE_TAG;
        end
        PH_SCOUNT_LO: begin
          have_rec = 1'b1;
          ctx = 1'b1;
          rkind = RK_SCOUNT;
          rcount = word;
          tl = word;
          ins = 1'b1;
          if (word == 16'd0) begin
            do_fd = 1'b1;
          end else begin
            ph = PH_TYPE_TAG;
          end
        end
        PH_TYPE_TAG: begin
          htt = b;
          if (b == VT_OBJECT || b == VT_UNINIT) begin
            ph = PH_TYPE_HI;
          end else begin
            do_type = 1'b1;
            rtval = 16'd0;
          end
        end
        PH_TYPE_LO: begin
          do_type = 1'b1;
          rtval = word;
        end
        default: begin
          // Byte after a complete table.
          have_rec = 1'b1;
          rkind = RK_NONE;
          end_f = 1'b1;
          st = ST_TRAILING;
        end
      endcase

      // Start of a frame: absolute offset and what follows the delta.
      if (do_start) begin
        prv = first_q ? {16'd0, delta} : prev_q + {16'd0, delta} + 32'd1;
        fst = 1'b0;
        have_rec = 1'b1;
        ctx = 1'b1;
        rkind = RK_FRAME;
        if (knd == FK_SL1) begin
          tl = 16'd1;
          ins = 1'b1;
          ph = PH_TYPE_TAG;
        end else if (knd == FK_APPEND) begin
          tl = {8'd0, tg} - {8'd0, TAG_SAME_EXT};
          ins = 1'b0;
          ph = PH_TYPE_TAG;
        end else if (knd == FK_FULL) begin
          ph = PH_LCOUNT_HI;
        end else begin
          do_fd = 1'b1;
        end
      end

      // A verification type completes.
      if (do_type) begin
        have_rec = 1'b1;
        ctx = 1'b1;
        rkind = in_stack_q ? RK_STYPE : RK_LTYPE;
        rttag = htt;
        tl = types_left_q - 16'd1;
        if (tl != 16'd0) begin
          ph = PH_TYPE_TAG;
        end else if (!in_stack_q && kind_q == FK_FULL) begin
          ph = PH_SCOUNT_HI;
        end else begin
          do_fd = 1'b1;
        end
      end

      // A frame completes.
      if (do_fd) begin
        fl = frames_left_q - 16'd1;
        ph = (fl == 16'd0) ? PH_DONE : PH_TAG;
      end

      // End of table and truncation.
      if (!end_f) begin
        if (ph == PH_DONE && have_rec) begin
          end_f = 1'b1;
        end else if (last) begin
          if (!have_rec) begin
            have_rec = 1'b1;
            ctx = 1'b0;
            rkind = RK_NONE;
            rcount = 16'd0;
            rttag = 8'd0;
            rtval = 16'd0;
          end
          end_f = 1'b1;
          st = ST_TRUNC;
        end
      end

      if (end_f && st != ST_OK) begin
        drn = 1'b1;
      end

      // Record assembly.
      chop_diff = TAG_SAME_EXT - tg;
      rec.record_kind     = rkind;
      rec.frame_kind      = ctx ? knd : 3'd0;
      rec.frame_tag       = ctx ? tg : 8'd0;
      rec.bytecode_offset = ctx ? prv : 32'd0;
      rec.locals_removed  = (ctx && knd == FK_CHOP) ? chop_diff[1:0] : 2'd0;
      rec.entry_count     = rcount;
      rec.type_tag        = rttag;
      rec.type_value      = rtval;
      rec.table_end       = end_f;
      rec.status          = st;
    end

    // Last byte returns every parser state register to its reset value.
    if (last) begin
      ph = PH_COUNT_HI; fl = 16'd0; fst = 1'b1; prv = 32'd0;
      knd = FK_SAME; tg = 8'd0; tl = 16'd0; ins = 1'b0;
      hh = 8'd0; htt = 8'd0; drn = 1'b0;
    end

    phase_d = ph;  frames_left_d = fl; first_d = fst; prev_d = prv;
    kind_d = knd;  tag_d = tg;         types_left_d = tl;
    in_stack_d = ins; held_hi_d = hh;  held_tt_d = htt; drain_d = drn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_COUNT_HI;
      frames_left_q <= 16'd0;
      first_q       <= 1'b1;
      prev_q        <= 32'd0;
      kind_q        <= FK_SAME;
      tag_q         <= 8'd0;
      types_left_q  <= 16'd0;
      in_stack_q    <= 1'b0;
      held_hi_q     <= 8'd0;
      held_tt_q     <= 8'd0;
      drain_q       <= 1'b0;
    end else if (fire) begin
      phase_q       <= phase_d;
      frames_left_q <= frames_left_d;
      first_q       <= first_d;
      prev_q        <= prev_d;
      kind_q        <= kind_d;
      tag_q         <= tag_d;
      types_left_q  <= types_left_d;
      in_stack_q    <= in_stack_d;
      held_hi_q     <= held_hi_d;
      held_tt_q     <= held_tt_d;
      drain_q       <= drain_d;
    end
  end

  // Result queue: two entries so the parser keeps going while a record waits.
  assign empty_o    = (res_cnt_q == 2'd0);
  assign out_item_o = res_q[res_rd_q];
  assign res_rd     = pop_i && !empty_o;

  always_comb begin
    res_cnt_d = res_cnt_q + {1'b0, fire && have_rec} - {1'b0, res_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_wr_q  <= 1'b0;
      res_rd_q  <= 1'b0;
      res_cnt_q <= 2'd0;
    end else begin
      if (fire && have_rec) begin
        res_wr_q <= !res_wr_q;
      end
      if (res_rd) begin
        res_rd_q <= !res_rd_q;
      end
      res_cnt_q <= res_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && have_rec) begin
      res_q[res_wr_q] <= rec;
    end
  end

endmodule
